// File: design/missing_aware_correlation_filter_top_assert.svh
// Assertion macros shared by mcf_queue and mcf_back.
`ifndef MISSING_AWARE_CORRELATION_FILTER_TOP_ASSERT_SVH
`define MISSING_AWARE_CORRELATION_FILTER_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mcf_pkg.sv
package mcf_pkg;

  // Datapath sizes
  localparam int SAMPLE_WIDTH    = 16;
  localparam int ACC_WIDTH       = 48;
  localparam int SAMPLE_FRAC     = 11;
  localparam int CORR_FRAC       = 14;
  localparam int SCALE_WIDTH     = 32;
  localparam int CORR_WIDTH      = 16;
  localparam int THR_WIDTH       = 15;
  localparam int COUNT_WIDTH     = 32;
  localparam int PROD_WIDTH      = 2 * SAMPLE_WIDTH;
  localparam int ADD_WIDTH       = ((PROD_WIDTH > ACC_WIDTH) ? PROD_WIDTH : ACC_WIDTH) + 1;
  localparam int SCALE_SHIFT     = 2 * SAMPLE_FRAC + SCALE_WIDTH - CORR_FRAC;
  localparam int MAG_LO_WIDTH    = ACC_WIDTH / 2;
  localparam int MAG_HI_WIDTH    = ACC_WIDTH - MAG_LO_WIDTH;
  localparam int SUM_WIDTH       = ACC_WIDTH + SCALE_WIDTH;
  localparam int QUOT_WIDTH      = SUM_WIDTH - SCALE_SHIFT;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // Window queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ADD_WIDTH-1:0]    add_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic        [ACC_WIDTH-1:0]    mag_t;
  typedef logic signed [CORR_WIDTH-1:0]   corr_t;
  typedef logic        [CORR_WIDTH-1:0]   corr_mag_t;
  typedef logic        [THR_WIDTH-1:0]    thr_t;
  typedef logic        [SCALE_WIDTH-1:0]  scale_t;
  typedef logic        [COUNT_WIDTH-1:0]  count_t;
  typedef logic        [SUM_WIDTH-1:0]    sum_t;
  typedef logic        [QUOT_WIDTH-1:0]   quot_t;

  localparam acc_t   ACC_MAX    = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t   ACC_MIN    = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam sum_t   ROUND_BIAS = sum_t'(1) << (SCALE_SHIFT - 1);
  localparam int     CORR_POS_LIMIT = 32767;
  localparam int     CORR_NEG_LIMIT = 32768;
  localparam corr_t  CORR_MAX   = 16'sh7fff;
  localparam corr_t  CORR_MIN   = -16'sh8000;
  localparam count_t COUNT_MAX  = '1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_INV_COUNT_SCALE = 3'd0,
    CFG_ASYM_MODE       = 3'd1,
    CFG_ABS_THRESHOLD   = 3'd2,
    CFG_NEG_THRESHOLD   = 3'd3,
    CFG_POS_THRESHOLD   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    scale_t inv_count_scale;
    logic   asym_mode;
    thr_t   abs_threshold;
    thr_t   neg_threshold;
    thr_t   pos_threshold;
  } cfg_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] count;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_LO,
    B_MUL_HI,
    B_SUM,
    B_DONE
  } back_state_t;

endpackage

// File: design/mcf_in_if.sv
interface mcf_in_if;
  logic             valid;
  logic             ready;
  mcf_pkg::sample_t window_sample;
  logic             window_missing;
  mcf_pkg::sample_t ref_sample;
  logic             ref_missing;
  logic             last_sample;

  modport source (
    output valid, window_sample, window_missing, ref_sample, ref_missing, last_sample,
    input  ready
  );
  modport sink (
    input  valid, window_sample, window_missing, ref_sample, ref_missing, last_sample,
    output ready
  );
endinterface

// File: design/mcf_out_if.sv
interface mcf_out_if;
  logic            valid;
  logic            ready;
  mcf_pkg::corr_t  corr;
  logic            keep;
  mcf_pkg::count_t tested_count;
  mcf_pkg::count_t kept_count;
  mcf_pkg::corr_t  min_corr;
  mcf_pkg::corr_t  max_corr;

  modport source (
    output valid, corr, keep, tested_count, kept_count, min_corr, max_corr,
    input  ready
  );
  modport sink (
    input  valid, corr, keep, tested_count, kept_count, min_corr, max_corr,
    output ready
  );
endinterface

// File: design/mcf_front.sv
module mcf_front (
  input  logic               clk,
  input  logic               rst,
  mcf_in_if.sink             samples,
  input  mcf_pkg::q_status_t qstat,
  output logic               push,
  output mcf_pkg::acc_t      push_data
);
  import mcf_pkg::*;

  logic  accept;
  logic  p_valid;
  logic  p_last;
  prod_t prod;
  acc_t  acc;
  add_t  sum;
  acc_t  acc_sat;

  // Leave one queue slot for the item sitting in the product stage
  assign samples.ready = (qstat.count <= QCW'(QDEPTH - 2));
  assign accept        = samples.valid && samples.ready;

  // Multiply stage: a missing side contributes a zero product
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_last <= samples.last_sample;
      if (samples.window_missing || samples.ref_missing) begin
        prod <= '0;
      end else begin
        prod <= prod_t'(samples.window_sample) * prod_t'(samples.ref_sample);
      end
    end
  end

  // Saturating accumulate
  always_comb begin
    sum = add_t'(acc) + add_t'(prod);
    if (sum > add_t'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (sum < add_t'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_t'(sum);
    end
  end

  // Hand the finished window sum to the queue and clear
  assign push      = p_valid && p_last;
  assign push_data = acc_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= p_last ? '0 : acc_sat;
    end
  end

endmodule

// File: design/mcf_queue.sv
module mcf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcf_pkg::acc_t      push_data,
  input  logic               pop,
  output mcf_pkg::acc_t      pop_data,
  output mcf_pkg::q_status_t stat
);
  import mcf_pkg::*;
  `include "missing_aware_correlation_filter_top_assert.svh"

  acc_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  // Store pushed window sums
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

  `ASSERT_IMPLIES(q_no_overflow, clk, rst, push && !pop, count < QCW'(QDEPTH), "queue overflow")
  `ASSERT_IMPLIES(q_no_underflow, clk, rst, pop, count != '0, "queue underflow")
  `ASSERT_ALWAYS(q_count_bound, clk, rst, count <= QCW'(QDEPTH), "queue count out of range")

endmodule

// File: design/mcf_back.sv
module mcf_back (
  input  logic               clk,
  input  logic               rst,
  input  mcf_pkg::cfg_t      cfg,
  input  mcf_pkg::q_status_t qstat,
  input  mcf_pkg::acc_t      pop_data,
  output logic               pop,
  mcf_out_if.source          results
);
  import mcf_pkg::*;
  `include "missing_aware_correlation_filter_top_assert.svh"

  back_state_t state;
  back_state_t state_next;

  logic                              neg;
  mag_t                              mag;
  logic [MAG_LO_WIDTH+SCALE_WIDTH-1:0] p_lo;
  logic [MAG_HI_WIDTH+SCALE_WIDTH-1:0] p_hi;
  sum_t                              sum;

  logic      load;
  logic      out_valid;
  quot_t     quot;
  corr_mag_t r_mag;
  corr_t     r;
  logic      keep_now;

  corr_t  corr;
  logic   keep;
  count_t tested_total;
  count_t kept_total;
  corr_t  running_min;
  corr_t  running_max;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!qstat.empty) state_next = B_MUL_LO;
      B_MUL_LO: state_next = B_MUL_HI;
      B_MUL_HI: state_next = B_SUM;
      B_SUM:    state_next = B_DONE;
      B_DONE:   if (!out_valid || results.ready) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      B_IDLE:  pop  = !qstat.empty;
      B_DONE:  load = !out_valid || results.ready;
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scale the window sum magnitude by the reciprocal in two partial products
  always_ff @(posedge clk) begin
    if (pop) begin
      neg <= pop_data[ACC_WIDTH-1];
      mag <= pop_data[ACC_WIDTH-1] ? mag_t'(-pop_data) : mag_t'(pop_data);
    end
    if (state == B_MUL_LO) begin
      p_lo <= (MAG_LO_WIDTH+SCALE_WIDTH)'(mag[MAG_LO_WIDTH-1:0]) *
              (MAG_LO_WIDTH+SCALE_WIDTH)'(cfg.inv_count_scale);
    end
    if (state == B_MUL_HI) begin
      p_hi <= (MAG_HI_WIDTH+SCALE_WIDTH)'(mag[ACC_WIDTH-1:MAG_LO_WIDTH]) *
              (MAG_HI_WIDTH+SCALE_WIDTH)'(cfg.inv_count_scale);
    end
    if (state == B_SUM) begin
      sum <= sum_t'(p_lo) + (sum_t'(p_hi) << MAG_LO_WIDTH) + ROUND_BIAS;
    end
  end

  // Saturate to Q1.14 and apply the threshold rule
  always_comb begin
    quot = sum[SUM_WIDTH-1:SCALE_SHIFT];
    if (neg) begin
      r_mag = (quot >= quot_t'(CORR_NEG_LIMIT)) ? corr_mag_t'(CORR_NEG_LIMIT)
                                                : quot[CORR_WIDTH-1:0];
    end else begin
      r_mag = (quot >= quot_t'(CORR_POS_LIMIT)) ? corr_mag_t'(CORR_POS_LIMIT)
                                                : quot[CORR_WIDTH-1:0];
    end
    r = neg ? corr_t'(corr_mag_t'(0) - r_mag) : corr_t'(r_mag);
    if (cfg.asym_mode) begin
      keep_now = (neg && (cfg.neg_threshold != '0) &&
                  (r_mag >= corr_mag_t'(cfg.neg_threshold))) ||
                 (!neg && (cfg.pos_threshold != '0) &&
                  (r_mag >= corr_mag_t'(cfg.pos_threshold)));
    end else begin
      keep_now = (r_mag >= corr_mag_t'(cfg.abs_threshold));
    end
  end

  // Result register and running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      tested_total <= '0;
      kept_total   <= '0;
      running_min  <= CORR_MAX;
      running_max  <= CORR_MIN;
    end else if (load) begin
      out_valid <= 1'b1;
      if (tested_total != COUNT_MAX) begin
        tested_total <= tested_total + COUNT_WIDTH'(1);
      end
      if (keep_now && (kept_total != COUNT_MAX)) begin
        kept_total <= kept_total + COUNT_WIDTH'(1);
      end
      if (r < running_min) begin
        running_min <= r;
      end
      if (r > running_max) begin
        running_max <= r;
      end
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corr <= r;
      keep <= keep_now;
    end
  end

  assign results.valid        = out_valid;
  assign results.corr         = corr;
  assign results.keep         = keep;
  assign results.tested_count = tested_total;
  assign results.kept_count   = kept_total;
  assign results.min_corr     = running_min;
  assign results.max_corr     = running_max;

  `ASSERT_NEXT(back_pop_starts, clk, rst, pop, state == B_MUL_LO, "pop did not start a window")

endmodule

// File: design/missing_aware_correlation_filter_top.sv
// Missing-aware correlation filter.
// samples: one standardized (window, reference) pair per transfer, Q5.11, each with
//   a missing flag; last_sample closes a window. A pair with a missing side adds nothing.
// results: one transfer per window: saturated Q1.14 correlation, keep flag, saturating
//   tested and kept counts, and running min and max of the correlation.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 scale, 1 asym_mode,
//   2 abs, 3 neg, 4 pos threshold); other indexes are ignored. Write only while idle.
// Throughput: one sample per cycle into the multiply-accumulate front end while
// samples.ready is high. Each window then passes through the back end in order:
// pop, two partial products of the 48 by 32 bit scaling multiply, the rounding
// add, and the result stage; the back end pops no new window until it is done.
// A 4-entry queue of window sums sits between them; windows that arrive faster
// than the back end drains them fill it and samples.ready drops until it catches up.
// Each result is registered after its sum passes the product stage, queue and back end.
// A stalled receiver holds the result register; the back end waits, the queue
// fills, and then samples.ready goes low.
// Reset (rst, synchronous) clears the accumulator, queue, counters, configuration
// registers and result valid flag, and sets the running min to 32767 and max to -32768.
module missing_aware_correlation_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mcf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [mcf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  mcf_in_if.sink                                samples,
  mcf_out_if.source                             results
);
  import mcf_pkg::*;

  cfg_t      cfg;
  q_status_t qstat;
  logic      push;
  acc_t      push_data;
  logic      pop;
  acc_t      pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_COUNT_SCALE: cfg.inv_count_scale <= cfg_data[SCALE_WIDTH-1:0];
        CFG_ASYM_MODE:       cfg.asym_mode       <= cfg_data[0];
        CFG_ABS_THRESHOLD:   cfg.abs_threshold   <= cfg_data[THR_WIDTH-1:0];
        CFG_NEG_THRESHOLD:   cfg.neg_threshold   <= cfg_data[THR_WIDTH-1:0];
        CFG_POS_THRESHOLD:   cfg.pos_threshold   <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  mcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  mcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .qstat    (qstat),
    .pop_data (pop_data),
    .pop      (pop),
    .results  (results)
  );

endmodule
